// ===== sv/smbr_pkg.sv =====
// ============================================================================
// smbr_pkg: shared types and constants for the bounded random generator
// Mixer constants, digit widths and step counts of the serial units, FSM codes.
// ============================================================================
package smbr_pkg;

    localparam int WORD_W        = 64;
    localparam int DIGIT_W       = 4;
    localparam int MUL_STEPS     = WORD_W / DIGIT_W;
    localparam int MUL_CNT_W     = $clog2(MUL_STEPS);
    localparam int DIV_STEPS     = WORD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] SEED_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL1   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL2   = 64'h94d0_49bb_1331_11eb;
    localparam logic [WORD_W-1:0] WORD_ONES  = '1;

    localparam int MIX_SHIFT0    = 30;
    localparam int MIX_SHIFT1    = 27;
    localparam int MIX_SHIFT2    = 31;
    // uniform keeps the top 53 bits: fraction = value * 2^-53
    localparam int UNIFORM_SHIFT = 11;

    localparam logic OP_UNIFORM = 1'b0;
    localparam logic OP_BOUNDED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_CHK,
        S_DONE
    } t_state;

    typedef enum logic {
        MUL_SEL_1,
        MUL_SEL_2
    } t_mul_sel;

    // status of a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // mixer constant times one digit, low word
    function automatic logic [WORD_W-1:0] digit_multiple(t_mul_sel sel,
                                                         logic [DIGIT_W-1:0] d);
        logic [WORD_W-1:0] c;
        unique case (sel)
            MUL_SEL_1: c = MIX_MUL1;
            MUL_SEL_2: c = MIX_MUL2;
            default:   c = MIX_MUL1;
        endcase
        return c * {{(WORD_W-DIGIT_W){1'b0}}, d};
    endfunction

endpackage

// ===== sv/smbr_mul.sv =====
// ============================================================================
// smbr_mul: digit-serial multiply by a mixer constant
// Horner form, most significant digit first, low 64 bits of the product.
// ============================================================================
module smbr_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  smbr_pkg::t_mul_sel           i_sel,
    input  logic [smbr_pkg::WORD_W-1:0]  i_operand,
    output smbr_pkg::t_unit_stat         o_stat,
    output logic [smbr_pkg::WORD_W-1:0]  o_product
);

    logic [smbr_pkg::WORD_W-1:0]    r_operand;
    logic [smbr_pkg::WORD_W-1:0]    r_acc;
    smbr_pkg::t_mul_sel             r_sel;
    logic [smbr_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == smbr_pkg::MUL_CNT_W'(smbr_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_operand <= i_operand;
            r_sel     <= i_sel;
            r_acc     <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[smbr_pkg::WORD_W-smbr_pkg::DIGIT_W-1:0],
                      {smbr_pkg::DIGIT_W{1'b0}}}
                   + smbr_pkg::digit_multiple(
                         r_sel,
                         r_operand[smbr_pkg::WORD_W-1 -: smbr_pkg::DIGIT_W]);
            r_operand <= r_operand << smbr_pkg::DIGIT_W;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule

// ===== sv/smbr_rem.sv =====
// ============================================================================
// smbr_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ============================================================================
module smbr_rem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [smbr_pkg::WORD_W-1:0]  i_dividend,
    input  logic [smbr_pkg::WORD_W-1:0]  i_divisor,
    output smbr_pkg::t_unit_stat         o_stat,
    output logic [smbr_pkg::WORD_W-1:0]  o_rem
);

    logic [smbr_pkg::WORD_W-1:0]    r_dividend;
    logic [smbr_pkg::WORD_W-1:0]    r_divisor;
    logic [smbr_pkg::WORD_W-1:0]    r_rem;
    logic [smbr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [smbr_pkg::WORD_W:0] trial;
    logic [smbr_pkg::WORD_W:0] diff;
    logic                      fits;

    assign trial = {r_rem, r_dividend[smbr_pkg::WORD_W-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign fits  = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == smbr_pkg::DIV_CNT_W'(smbr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= fits ? diff[smbr_pkg::WORD_W-1:0]
                               : trial[smbr_pkg::WORD_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// ===== sv/splitmix64_bounded_random.sv =====
// ============================================================================
// splitmix64_bounded_random: SplitMix64 generator with bounded draws
// Uniform 53-bit fractions and rejection-sampled integers in [low, high].
// ============================================================================
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries opcode, range_low and
//   range_high. Result channel (o_out_valid / i_out_stall) carries one
//   result_value per request. One request is in flight at a time.
//   i_cfg_we / i_cfg_wdata load the running seed; write only while idle.
// Path from request accept to result valid:
//   uniform                 gamma add, then two digit-serial mixer muls
//   bounded, empty/reversed straight to the result, seed untouched
//   bounded, full 64-bit    as uniform, no remainder
//   bounded, general        draw, remainder, check; redrawn on reject
//   The bit-serial remainder is the long step of the bounded path; the 4-bit
//   digit multiplier serves both mixer multiplies.
// Request pacing: next request accepted the cycle after the result moves into
// the output register; none is accepted while a request is in flight.
// Reset: synchronous, active low; clears the running seed to zero and
// empties the output register.
// Stall: a finished result sits in the output register while the receiver
// stalls; the next request may still be processed, and its result waits
// inside until the output register frees.
// ============================================================================
module splitmix64_bounded_random (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [smbr_pkg::WORD_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [smbr_pkg::WORD_W-1:0]  i_range_low,
    input  logic [smbr_pkg::WORD_W-1:0]  i_range_high,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [smbr_pkg::WORD_W-1:0]  o_result_value
);

    smbr_pkg::t_state            r_state, n_state;
    logic [smbr_pkg::WORD_W-1:0] r_seed;
    logic                        r_op;
    logic                        r_full;
    logic [smbr_pkg::WORD_W-1:0] r_lo;
    logic [smbr_pkg::WORD_W-1:0] r_span;
    logic [smbr_pkg::WORD_W-1:0] r_z;       // draw, block base, then result
    logic [smbr_pkg::WORD_W-1:0] r_out;
    logic                        r_out_valid;

    logic                        in_accept;
    logic                        out_take;
    logic                        out_free;
    logic [smbr_pkg::WORD_W-1:0] seed_adv;
    logic [smbr_pkg::WORD_W-1:0] mix0;
    logic [smbr_pkg::WORD_W-1:0] mix1;
    logic [smbr_pkg::WORD_W-1:0] mix2;
    logic [smbr_pkg::WORD_W-1:0] span_in;
    logic                        empty_in;
    logic                        full_in;
    logic [smbr_pkg::WORD_W:0]   chk_sum;
    logic                        reject;

    logic                        mul_start;
    smbr_pkg::t_mul_sel          mul_sel;
    logic [smbr_pkg::WORD_W-1:0] mul_operand;
    smbr_pkg::t_unit_stat        mul_stat;
    logic [smbr_pkg::WORD_W-1:0] mul_product;
    logic                        div_start;
    smbr_pkg::t_unit_stat        div_stat;
    logic [smbr_pkg::WORD_W-1:0] div_rem;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign seed_adv = r_seed + smbr_pkg::SEED_GAMMA;
    assign mix0     = seed_adv ^ (seed_adv >> smbr_pkg::MIX_SHIFT0);
    assign mix1     = mul_product ^ (mul_product >> smbr_pkg::MIX_SHIFT1);
    assign mix2     = mul_product ^ (mul_product >> smbr_pkg::MIX_SHIFT2);

    assign span_in  = i_range_high - i_range_low + 64'd1;
    assign empty_in = (i_range_high <= i_range_low);
    assign full_in  = (i_range_low == '0) && (i_range_high == smbr_pkg::WORD_ONES);

    // Reject iff the span-sized block holding x reaches 2^64-1, i.e. the
    // block base (x - x mod span) plus span carries out. Same test as
    // x >= 2^64-1 - ((2^64-1) mod span).
    assign chk_sum = {1'b0, r_z} + {1'b0, r_span};
    assign reject  = chk_sum[smbr_pkg::WORD_W];

    smbr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_sel     (mul_sel),
        .i_operand (mul_operand),
        .o_stat    (mul_stat),
        .o_product (mul_product)
    );

    smbr_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mix2),
        .i_divisor  (r_span),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smbr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        mul_start   = 1'b0;
        mul_sel     = smbr_pkg::MUL_SEL_1;
        mul_operand = mix0;
        div_start   = 1'b0;
        unique case (r_state)
            smbr_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_opcode == smbr_pkg::OP_BOUNDED && empty_in) begin
                        n_state = smbr_pkg::S_DONE;
                    end else begin
                        n_state = smbr_pkg::S_DRAW;
                    end
                end
            end
            smbr_pkg::S_DRAW: begin
                mul_start = 1'b1;
                n_state   = smbr_pkg::S_MUL1;
            end
            smbr_pkg::S_MUL1: begin
                if (mul_stat.done) begin
                    mul_start   = 1'b1;
                    mul_sel     = smbr_pkg::MUL_SEL_2;
                    mul_operand = mix1;
                    n_state     = smbr_pkg::S_MUL2;
                end
            end
            smbr_pkg::S_MUL2: begin
                if (mul_stat.done) begin
                    if (r_op == smbr_pkg::OP_UNIFORM || r_full) begin
                        n_state = smbr_pkg::S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = smbr_pkg::S_DIV;
                    end
                end
            end
            smbr_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_state = smbr_pkg::S_CHK;
                end
            end
            smbr_pkg::S_CHK: begin
                n_state = reject ? smbr_pkg::S_DRAW : smbr_pkg::S_DONE;
            end
            smbr_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = smbr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = smbr_pkg::S_IDLE;
            end
        endcase
    end

    // running seed: config write reloads, each draw advances by gamma
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end else if (r_state == smbr_pkg::S_DRAW) begin
            r_seed <= seed_adv;
        end
    end

    // request fields and working value
    always_ff @(posedge i_clk) begin
        if (r_state == smbr_pkg::S_IDLE && in_accept) begin
            r_op   <= i_opcode;
            r_lo   <= i_range_low;
            r_span <= span_in;
            r_full <= full_in;
            r_z    <= i_range_low;      // result for empty bounds
        end else if (r_state == smbr_pkg::S_MUL2 && mul_stat.done) begin
            if (r_op == smbr_pkg::OP_UNIFORM) begin
                r_z <= {{smbr_pkg::UNIFORM_SHIFT{1'b0}},
                        mix2[smbr_pkg::WORD_W-1:smbr_pkg::UNIFORM_SHIFT]};
            end else begin
                r_z <= mix2;
            end
        end else if (r_state == smbr_pkg::S_DIV && div_stat.done) begin
            r_z <= r_z - div_rem;
        end else if (r_state == smbr_pkg::S_CHK && !reject) begin
            r_z <= r_lo + div_rem;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == smbr_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == smbr_pkg::S_DONE && out_free) begin
            r_out <= r_z;
        end
    end

    assign o_in_stall     = (r_state != smbr_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and remainder unit busy together");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smbr_pkg::S_CHK) |-> (div_rem < r_span))
        else $error("remainder not below span");

    a_uniform_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smbr_pkg::S_DONE && r_op == smbr_pkg::OP_UNIFORM)
        |-> (r_z[smbr_pkg::WORD_W-1 -: smbr_pkg::UNIFORM_SHIFT] == '0))
        else $error("uniform result has upper bits set");

    a_seed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != smbr_pkg::S_DRAW && !i_cfg_we) |=> $stable(r_seed))
        else $error("seed changed outside a draw or config write");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("request channel open right after accept");

endmodule

// ===== dv/tb_splitmix64_bounded_random.sv =====
// ============================================================================
// tb_splitmix64_bounded_random: self-checking bench for the bounded generator
// Walks a table of directed requests and then random phases under several
// seeds and idle/stall mixes. Every accepted request is run through a local
// SplitMix64 predictor; results are checked in order, fixed rows by value.
// ============================================================================
module tb_splitmix64_bounded_random;

    localparam int WORD_W = smbr_pkg::WORD_W;

    // Generator constants, kept local so that a bad package value is caught.
    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIXER_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIXER_MUL_B = 64'h94d0_49bb_1331_11eb;
    localparam logic [WORD_W-1:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam logic [WORD_W-1:0] HALF_SPAN   = 64'h8000_0000_0000_0000;
    localparam int XS_FIRST    = 30;
    localparam int XS_SECOND   = 27;
    localparam int XS_LAST     = 31;
    localparam int FRAC_DROP   = 11;   // uniform keeps the top 53 bits

    localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;   // ~190 rejected draws in a row
    localparam int TAIL_CYCLES    = 120;     // > worst single-draw latency

    // One directed request; 'fixed' rows carry a hand-written result.
    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] range_low;
        logic [WORD_W-1:0] range_high;
        logic              fixed;
        logic [WORD_W-1:0] want;
    } t_req_row;

    localparam int N_DIRECTED = 19;
    localparam t_req_row DIRECTED_ROWS [N_DIRECTED] = '{
        // uniform right after reset, range fields at both extremes
        '{smbr_pkg::OP_UNIFORM, 64'h0, 64'h0, 1'b0, 64'h0},
        '{smbr_pkg::OP_UNIFORM, ALL_ONES, ALL_ONES, 1'b0, 64'h0},
        // empty and reversed bounds: result is range_low, seed untouched
        '{smbr_pkg::OP_BOUNDED, 64'h0, 64'h0, 1'b1, 64'h0},
        '{smbr_pkg::OP_BOUNDED, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES},
        '{smbr_pkg::OP_BOUNDED, 64'd5, 64'd3, 1'b1, 64'd5},
        '{smbr_pkg::OP_BOUNDED, ALL_ONES, 64'h0, 1'b1, ALL_ONES},
        // full 64-bit span: raw draw, no division
        '{smbr_pkg::OP_BOUNDED, 64'h0, ALL_ONES, 1'b0, 64'h0},
        // two-value ranges at the bottom and the top
        '{smbr_pkg::OP_BOUNDED, 64'h0, 64'h1, 1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, ALL_ONES - 64'h1, ALL_ONES, 1'b0, 64'h0},
        // spans 2^63+1 and 2^63: about half the draws are rejected
        '{smbr_pkg::OP_BOUNDED, 64'h0, HALF_SPAN, 1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, 64'h0, HALF_SPAN - 64'h1, 1'b0, 64'h0},
        // span 2^64-1: only the all-ones draw is rejected
        '{smbr_pkg::OP_BOUNDED, 64'h1, ALL_ONES, 1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, 64'h0, ALL_ONES - 64'h1, 1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, 64'd100, 64'd199, 1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, HALF_SPAN, ALL_ONES, 1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, 64'h1, 64'h0, 1'b1, 64'h1},
        '{smbr_pkg::OP_UNIFORM, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
          1'b0, 64'h0},
        '{smbr_pkg::OP_BOUNDED, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
          1'b1, 64'haaaa_aaaa_aaaa_aaaa},
        '{smbr_pkg::OP_UNIFORM, 64'h0, ALL_ONES, 1'b0, 64'h0}
    };

    // DUT ports
    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WORD_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_opcode;
    logic [WORD_W-1:0] i_range_low;
    logic [WORD_W-1:0] i_range_high;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [WORD_W-1:0] o_result_value;

    // Predictor state and bookkeeping
    logic [WORD_W-1:0] gen_seed;          // mirror of the running seed
    logic [WORD_W-1:0] pending_values[$]; // predicted results, oldest first
    int                mismatch_count;
    int                req_idle_pct;      // sender idle chance, percent
    int                out_stall_pct;     // receiver stall chance, percent
    logic              hold_active;       // long hold-off in progress
    event              hold_go;
    int                quiet_cycles;

    splitmix64_bounded_random u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Advance the mirrored seed by one step and return the mixed value.
    function automatic logic [WORD_W-1:0] next_mixed();
        logic [WORD_W-1:0] z;
        gen_seed = gen_seed + GOLDEN_STEP;
        z = gen_seed;
        z = (z ^ (z >> XS_FIRST)) * MIXER_MUL_A;
        z = (z ^ (z >> XS_SECOND)) * MIXER_MUL_B;
        return z ^ (z >> XS_LAST);
    endfunction

    // Result of one request; advances the mirrored seed as the block does.
    function automatic logic [WORD_W-1:0] predict_value(logic op,
                                                        logic [WORD_W-1:0] lo,
                                                        logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] x;
        if (op == smbr_pkg::OP_UNIFORM) begin
            return next_mixed() >> FRAC_DROP;
        end
        // empty or reversed bounds: no draw at all
        if (hi <= lo) begin
            return lo;
        end
        span = hi - lo + 64'h1;
        // full span wraps to zero: one draw, taken as it is
        if (span == '0) begin
            return next_mixed();
        end
        // reject the uneven tail so every residue is equally likely
        limit = ALL_ONES - (ALL_ONES % span);
        do begin
            x = next_mixed();
        end while (x >= limit);
        return lo + (x % span);
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request and wait until it is taken. Valid is only lowered on
    // an idle cycle, so back-to-back requests never see a low/high pair of
    // assignments in one step. The expectation is booked at the accept edge.
    task automatic send_request(logic op, logic [WORD_W-1:0] lo,
                                logic [WORD_W-1:0] hi, logic fixed,
                                logic [WORD_W-1:0] want);
        logic [WORD_W-1:0] pred;
        while ($urandom_range(99) < req_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_range_low  <= lo;
        i_range_high <= hi;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        pred = predict_value(op, lo, hi);
        pending_values.push_back(fixed ? want : pred);
    endtask

    // Wait until the block is idle: request line low, every result back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Seed write: only called while the block is idle.
    task automatic load_seed(logic [WORD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_seed     = value;
    endtask

    // One random phase under a given seed and idle/stall mix. hold_at < 0
    // means no long receiver hold-off in this phase.
    task automatic run_phase(logic [WORD_W-1:0] seed, int idle_pct, int stall_pct,
                             int count, int hold_at);
        logic              op;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        int                kind;
        drain();
        load_seed(seed);
        req_idle_pct   = idle_pct;
        out_stall_pct <= stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) -> hold_go;
            op = smbr_pkg::OP_BOUNDED;
            lo = rand64();
            hi = rand64();
            kind = $urandom_range(99);
            if (kind < 30) begin
                // uniform; range fields are noise
                op = smbr_pkg::OP_UNIFORM;
            end else if (kind < 38) begin
                // empty or reversed bounds
                hi = lo - $urandom_range(0, 3);
            end else if (kind < 43) begin
                // full span
                lo = '0;
                hi = ALL_ONES;
            end else if (kind < 58) begin
                // small spans anywhere (may wrap into a reversed pair)
                hi = lo + $urandom_range(1, 1000);
            end else if (kind < 70) begin
                // power-of-two spans
                lo = $urandom_range(0, 1000);
                hi = lo + (64'h1 << $urandom_range(1, 62)) - 64'h1;
            end else if (kind < 78) begin
                // just above half the word: heavy rejection
                lo = $urandom_range(0, 255);
                hi = lo + HALF_SPAN + $urandom_range(0, 1023);
            end else if (kind < 88) begin
                // zero-based, span of random size
                lo = '0;
                hi = hi >> $urandom_range(0, 63);
            end else if (kind < 94) begin
                // upper bound near the top
                hi = ALL_ONES - $urandom_range(0, 15);
            end
            // remaining rows: both bounds fully random
            send_request(op, lo, hi, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check against the oldest expectation, then pick stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        logic [WORD_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_values.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result expected none actual %h",
                         $time, o_result_value);
            end else begin
                want = pending_values.pop_front();
                if (o_result_value !== want) begin
                    mismatch_count++;
                    $display("%0t: result_value mismatch expected %h actual %h",
                             $time, want, o_result_value);
                end
            end
        end
        i_out_stall <= hold_active || ($urandom_range(99) < out_stall_pct);
    end

    // Long hold-off, timed here so the sender keeps offering meanwhile.
    initial begin
        hold_active <= 1'b0;
        forever begin
            @hold_go;
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // Watchdog: too long without a request or a result moving.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_opcode       <= smbr_pkg::OP_UNIFORM;
        i_range_low    <= '0;
        i_range_high   <= '0;
        out_stall_pct  <= 0;
        req_idle_pct    = 0;
        mismatch_count  = 0;
        gen_seed        = '0;   // seed after reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, run from the reset seed
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].range_low,
                         DIRECTED_ROWS[r].range_high, DIRECTED_ROWS[r].fixed,
                         DIRECTED_ROWS[r].want);
        end

        // random phases: seed, idle %, stall %, requests, hold-off position
        run_phase(ALL_ONES, 0,  0,  120, 40);
        run_phase(rand64(), 65, 0,  140, -1);
        run_phase(64'h1,    0,  65, 140, -1);
        run_phase(rand64(), 32, 32, 140, -1);
        run_phase(64'h0,    0,  0,  140, 70);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_values.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/smbr_pkg.sv
sv/smbr_mul.sv
sv/smbr_rem.sv
sv/splitmix64_bounded_random.sv
dv/tb_splitmix64_bounded_random.sv
